// ===== hw/rtl/ttcw_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the character writer.
package ttcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);

  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;

  localparam int TAB_STOP = 8;

  localparam logic [CHAR_W-1:0] BLANK     = 8'h20;
  localparam logic [CHAR_W-1:0] CODE_BELL = 8'd7;
  localparam logic [CHAR_W-1:0] CODE_BS   = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_TAB  = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_LF   = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_CR   = 8'd13;
  localparam logic [CHAR_W-1:0] CODE_ESC  = 8'd27;

  typedef enum logic [1:0] {
    ACT_RECV  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    SEL_SWEEP  = 2'd0,
    SEL_CURSOR = 2'd1,
    SEL_READ   = 2'd2
  } addr_sel_t;

  typedef struct packed {
    logic      load;
    logic      exec;
    logic      addr_load;
    addr_sel_t addr_sel;
    logic      sweep_step;
    logic      write_char;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    print;
    logic    rd_in_range;
    logic    row_valid;
    logic    sweep_last;
    logic    out_free;
  } status_t;

endpackage

// ===== hw/rtl/ttcw_ctrl.sv =====
// Controller state machine that sequences each request through the datapath.
module ttcw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  ttcw_pkg::status_t st,
  output ttcw_pkg::cmd_t    cmd,
  output logic              idle
);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_DECODE     = 8'b0000_0010,
    S_SWEEP_ADDR = 8'b0000_0100,
    S_SWEEP      = 8'b0000_1000,
    S_ADDR       = 8'b0001_0000,
    S_WRITE      = 8'b0010_0000,
    S_READ       = 8'b0100_0000,
    S_DONE       = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign idle = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.addr_sel   = ttcw_pkg::SEL_CURSOR;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.print) begin
          state_next = st.row_valid ? S_ADDR : S_SWEEP_ADDR;
        end else if (st.act == ttcw_pkg::ACT_READ && st.rd_in_range) begin
          state_next = S_ADDR;
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_SWEEP_ADDR: begin
        cmd.addr_load = 1'b1;
        cmd.addr_sel  = ttcw_pkg::SEL_SWEEP;
        state_next    = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (st.sweep_last) begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.addr_load = 1'b1;
        if (st.act == ttcw_pkg::ACT_READ) begin
          cmd.addr_sel = ttcw_pkg::SEL_READ;
          state_next   = S_READ;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_char = 1'b1;
        state_next     = S_DONE;
      end
      S_READ: begin
        // The memory read data is registered during this cycle.
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/ttcw_dp.sv =====
// Datapath: screen memory, row blank marks, cursor, escape flag and result register.
module ttcw_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  ttcw_pkg::cmd_t                 cmd,
  output ttcw_pkg::status_t              st,
  input  ttcw_pkg::action_t              in_action,
  input  logic [ttcw_pkg::CHAR_W-1:0]    in_char,
  input  logic [ttcw_pkg::ROW_W-1:0]     in_row,
  input  logic [ttcw_pkg::COL_W-1:0]     in_col,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ttcw_pkg::CHAR_W-1:0]    out_cell,
  output logic [ttcw_pkg::COL_W-1:0]     out_col,
  output logic [ttcw_pkg::ROW_W-1:0]     out_row,
  output logic                           out_bell,
  output logic                           out_scrolled
);

  localparam logic [ttcw_pkg::COL_W-1:0] LAST_COL = ttcw_pkg::COL_W'(ttcw_pkg::COLUMNS - 1);
  localparam logic [ttcw_pkg::ROW_W-1:0] LAST_ROW = ttcw_pkg::ROW_W'(ttcw_pkg::ROWS - 1);

  // Request registers
  ttcw_pkg::action_t               act;
  logic [ttcw_pkg::CHAR_W-1:0]     code;
  logic [ttcw_pkg::ROW_W-1:0]      rrow;
  logic [ttcw_pkg::COL_W-1:0]      rcol;

  // Terminal state
  logic [ttcw_pkg::COL_W-1:0]      col, col_next;
  logic [ttcw_pkg::ROW_W-1:0]      row, row_next;
  logic [ttcw_pkg::ROW_W-1:0]      top, top_next;
  logic [ttcw_pkg::ROWS-1:0]       rvalid, rvalid_next;
  logic                            esc, esc_next;
  logic                            bell, bell_next;
  logic                            scr, scr_next;

  // Memory access
  logic [ttcw_pkg::CHAR_W-1:0]     mem [ttcw_pkg::CELLS];
  logic [ttcw_pkg::ADDR_W-1:0]     addr;
  logic [ttcw_pkg::CHAR_W-1:0]     rdata;
  logic [ttcw_pkg::COL_W-1:0]      cnt;
  logic                            rd_hit;
  logic                            rd_rv;

  logic [ttcw_pkg::ROW_W-1:0]      cur_phys;
  logic [ttcw_pkg::ROW_W-1:0]      rd_phys;
  logic [ttcw_pkg::ROW_W-1:0]      sel_phys;
  logic [ttcw_pkg::COL_W-1:0]      sel_col;
  logic [ttcw_pkg::COL_W:0]        tab_col;
  logic                            is_ctrl;
  logic                            do_lf;

  // Screen rows rotate: logical row 0 lives at physical row top.
  function automatic logic [ttcw_pkg::ROW_W-1:0] phys_row(
    input logic [ttcw_pkg::ROW_W-1:0] t,
    input logic [ttcw_pkg::ROW_W-1:0] r
  );
    logic [ttcw_pkg::ROW_W:0] sum;
    sum = {1'b0, t} + {1'b0, r};
    if (sum >= (ttcw_pkg::ROW_W+1)'(ttcw_pkg::ROWS)) begin
      sum = sum - (ttcw_pkg::ROW_W+1)'(ttcw_pkg::ROWS);
    end
    return sum[ttcw_pkg::ROW_W-1:0];
  endfunction

  assign cur_phys = phys_row(top, row);
  assign rd_phys  = phys_row(top, rrow);

  assign is_ctrl = (code == ttcw_pkg::CODE_ESC) || (code == ttcw_pkg::CODE_CR) ||
                   (code == ttcw_pkg::CODE_LF)  || (code == ttcw_pkg::CODE_TAB) ||
                   (code == ttcw_pkg::CODE_BS)  || (code == ttcw_pkg::CODE_BELL);

  assign st.act         = act;
  assign st.print       = (act == ttcw_pkg::ACT_RECV) && !esc && !is_ctrl;
  assign st.rd_in_range = ({1'b0, rrow} < (ttcw_pkg::ROW_W+1)'(ttcw_pkg::ROWS)) &&
                          ({1'b0, rcol} < (ttcw_pkg::COL_W+1)'(ttcw_pkg::COLUMNS));
  assign st.row_valid   = rvalid[cur_phys];
  assign st.sweep_last  = (cnt == LAST_COL);
  assign st.out_free    = !out_valid || out_ready;

  assign tab_col = {1'b0, col} + (ttcw_pkg::COL_W+1)'(ttcw_pkg::TAB_STOP)
                 - (ttcw_pkg::COL_W+1)'(col % ttcw_pkg::TAB_STOP);

  always_comb begin
    col_next    = col;
    row_next    = row;
    top_next    = top;
    rvalid_next = rvalid;
    esc_next    = esc;
    bell_next   = bell;
    scr_next    = scr;
    do_lf       = 1'b0;

    if (cmd.load) begin
      bell_next = 1'b0;
      scr_next  = 1'b0;
    end

    if (cmd.exec) begin
      case (act)
        ttcw_pkg::ACT_RECV: begin
          if (code == ttcw_pkg::CODE_ESC) begin
            esc_next = 1'b1;
          end else if (esc) begin
            esc_next = 1'b0;
          end else if (code == ttcw_pkg::CODE_CR) begin
            col_next = '0;
          end else if (code == ttcw_pkg::CODE_LF) begin
            do_lf = 1'b1;
          end else if (code == ttcw_pkg::CODE_TAB) begin
            if (tab_col > {1'b0, LAST_COL}) begin
              col_next = LAST_COL;
            end else begin
              col_next = tab_col[ttcw_pkg::COL_W-1:0];
            end
          end else if (code == ttcw_pkg::CODE_BS) begin
            if (col != '0) begin
              col_next = col - 1'b1;
            end
          end else if (code == ttcw_pkg::CODE_BELL) begin
            bell_next = 1'b1;
          end
        end
        ttcw_pkg::ACT_CLEAR: begin
          col_next    = '0;
          row_next    = '0;
          top_next    = '0;
          rvalid_next = '0;
          esc_next    = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (cmd.write_char) begin
      if (col == LAST_COL) begin
        col_next = '0;
        do_lf    = 1'b1;
      end else begin
        col_next = col + 1'b1;
      end
    end

    if (cmd.sweep_step && st.sweep_last) begin
      rvalid_next[cur_phys] = 1'b1;
    end

    // A scroll only marks the old top row blank; it is filled before its first write.
    if (do_lf) begin
      if (row == LAST_ROW) begin
        rvalid_next[top] = 1'b0;
        top_next         = (top == LAST_ROW) ? '0 : top + 1'b1;
        scr_next         = 1'b1;
      end else begin
        row_next = row + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col    <= '0;
      row    <= '0;
      top    <= '0;
      rvalid <= '0;
      esc    <= 1'b0;
      bell   <= 1'b0;
      scr    <= 1'b0;
    end else begin
      col    <= col_next;
      row    <= row_next;
      top    <= top_next;
      rvalid <= rvalid_next;
      esc    <= esc_next;
      bell   <= bell_next;
      scr    <= scr_next;
    end
  end

  always_comb begin
    case (cmd.addr_sel)
      ttcw_pkg::SEL_SWEEP: begin
        sel_phys = cur_phys;
        sel_col  = '0;
      end
      ttcw_pkg::SEL_READ: begin
        sel_phys = rd_phys;
        sel_col  = rcol;
      end
      default: begin
        sel_phys = cur_phys;
        sel_col  = col;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act    <= in_action;
      code   <= in_char;
      rrow   <= in_row;
      rcol   <= in_col;
      rd_hit <= 1'b0;
    end
    if (cmd.addr_load) begin
      addr <= ttcw_pkg::ADDR_W'(sel_phys) * ttcw_pkg::ADDR_W'(ttcw_pkg::COLUMNS)
            + ttcw_pkg::ADDR_W'(sel_col);
      cnt  <= '0;
      if (cmd.addr_sel == ttcw_pkg::SEL_READ) begin
        rd_hit <= 1'b1;
        rd_rv  <= rvalid[rd_phys];
      end
    end else if (cmd.sweep_step) begin
      addr <= addr + 1'b1;
      cnt  <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      mem[addr] <= ttcw_pkg::BLANK;
    end else if (cmd.write_char) begin
      mem[addr] <= code;
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      // A row still marked blank reads as spaces.
      out_cell     <= rd_hit ? (rd_rv ? rdata : ttcw_pkg::BLANK) : '0;
      out_col      <= col;
      out_row      <= row;
      out_bell     <= bell;
      out_scrolled <= scr;
    end
  end

endmodule

// ===== hw/rtl/text_terminal_char_writer_core.sv =====
// Top level of the character screen writer: stream ports, controller and datapath.
// Each request returns exactly one result. A control byte, a swallowed byte, a clear,
// a read outside the screen or an unused action passes through the states DECODE and
// DONE; a cell read and a byte stored into a row already in use pass through DECODE,
// ADDR, then READ or WRITE, and DONE. DONE waits while the output register is full.
// Scrolling and clearing only mark rows blank, so the first byte stored into such a
// row first fills it with spaces, one cell per cycle through the single memory write
// port, in SWEEP_ADDR and SWEEP. A new request is taken once the previous one has
// reached the output register.
module text_terminal_char_writer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // action[1:0], char_code[9:2], read_row[14:10], read_col[21:15]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // cell_char[7:0], cursor_col[14:8], cursor_row[19:15],
                                 // bell[20], scrolled[21]
);

  ttcw_pkg::cmd_t    cmd;
  ttcw_pkg::status_t st;
  logic              idle;

  logic [ttcw_pkg::CHAR_W-1:0] cell_char;
  logic [ttcw_pkg::COL_W-1:0]  ccol;
  logic [ttcw_pkg::ROW_W-1:0]  crow;
  logic                        bell;
  logic                        scrolled;

  assign s_tready = idle;

  ttcw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (s_tvalid && s_tready),
    .st     (st),
    .cmd    (cmd),
    .idle   (idle)
  );

  ttcw_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .in_action    (ttcw_pkg::action_t'(s_tdata[1:0])),
    .in_char      (s_tdata[9:2]),
    .in_row       (s_tdata[14:10]),
    .in_col       (s_tdata[21:15]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_cell     (cell_char),
    .out_col      (ccol),
    .out_row      (crow),
    .out_bell     (bell),
    .out_scrolled (scrolled)
  );

  assign m_tdata = {2'b00, scrolled, bell, crow, ccol, cell_char};

endmodule

// ===== test/tb_text_terminal_char_writer_core.sv =====
// Self-checking testbench for the character screen writer: random and directed requests
// against an in-bench screen predictor.
module tb_text_terminal_char_writer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM    = 600;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT    = 21;

  localparam int CHAR_W   = ttcw_pkg::CHAR_W;
  localparam int ROW_W    = ttcw_pkg::ROW_W;
  localparam int COL_W    = ttcw_pkg::COL_W;
  localparam int ROWS     = ttcw_pkg::ROWS;
  localparam int COLUMNS  = ttcw_pkg::COLUMNS;
  localparam int TAB_STOP = ttcw_pkg::TAB_STOP;

  typedef struct {
    ttcw_pkg::action_t act;
    logic [CHAR_W-1:0] code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    bit                near;
  } request_t;

  typedef struct {
    logic [CHAR_W-1:0] char_val;
    logic [COL_W-1:0]  ccol;
    logic [ROW_W-1:0]  crow;
    logic              bell;
    logic              scrolled;
  } screen_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  text_terminal_char_writer_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted screen contents and cursor.
  logic [CHAR_W-1:0] screen [ROWS][COLUMNS];
  int cur_col;
  int cur_row;
  bit esc_armed;

  request_t       pending_reqs[$];
  screen_result_t expected_results[$];
  request_t       in_flight;

  int n_sent, n_results, n_errors;
  int n_bytes, n_reads, n_clears, n_scrolls, n_wraps;
  int quiet_cycles;
  int hold_left;
  bit hold_done;

  function automatic void blank_all();
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLUMNS; c++) begin
        screen[r][c] = ttcw_pkg::BLANK;
      end
    end
    cur_col = 0;
    cur_row = 0;
    esc_armed = 1'b0;
  endfunction

  function automatic bit line_feed();
    if (cur_row >= ROWS - 1) begin
      for (int r = 0; r < ROWS - 1; r++) begin
        screen[r] = screen[r + 1];
      end
      for (int c = 0; c < COLUMNS; c++) begin
        screen[ROWS-1][c] = ttcw_pkg::BLANK;
      end
      cur_row = ROWS - 1;
      return 1'b1;
    end
    cur_row++;
    return 1'b0;
  endfunction

  function automatic screen_result_t apply_request(request_t rq);
    screen_result_t res;
    int nx;
    res = '{default: '0};
    case (rq.act)
      ttcw_pkg::ACT_RECV: begin
        if (rq.code == ttcw_pkg::CODE_ESC) begin
          esc_armed = 1'b1;
        end else if (esc_armed) begin
          esc_armed = 1'b0;
        end else if (rq.code == ttcw_pkg::CODE_CR) begin
          cur_col = 0;
        end else if (rq.code == ttcw_pkg::CODE_LF) begin
          res.scrolled = line_feed();
        end else if (rq.code == ttcw_pkg::CODE_TAB) begin
          nx = cur_col + TAB_STOP - (cur_col % TAB_STOP);
          cur_col = (nx > COLUMNS - 1) ? COLUMNS - 1 : nx;
        end else if (rq.code == ttcw_pkg::CODE_BS) begin
          if (cur_col > 0) cur_col--;
        end else if (rq.code == ttcw_pkg::CODE_BELL) begin
          res.bell = 1'b1;
        end else begin
          screen[cur_row][cur_col] = rq.code;
          if (cur_col >= COLUMNS - 1) begin
            cur_col = 0;
            n_wraps++;
            res.scrolled = line_feed();
          end else begin
            cur_col++;
          end
        end
      end
      ttcw_pkg::ACT_READ: begin
        if (rq.row < ROWS && rq.col < COLUMNS) res.char_val = screen[rq.row][rq.col];
      end
      ttcw_pkg::ACT_CLEAR: blank_all();
      default: ;
    endcase
    res.ccol = COL_W'(cur_col);
    res.crow = ROW_W'(cur_row);
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_char();
    return CHAR_W'($urandom);
  endfunction

  task automatic queue_req(ttcw_pkg::action_t a, logic [CHAR_W-1:0] c, int unsigned r,
                           int unsigned cl, bit nr);
    request_t rq;
    rq.act  = a;
    rq.code = c;
    rq.row  = ROW_W'(r);
    rq.col  = COL_W'(cl);
    rq.near = nr;
    pending_reqs.push_back(rq);
  endtask

  // Request driver.
  always @(posedge clk) begin
    request_t rq;
    screen_result_t res;
    int r;
    bit calm;
    if (rst) begin
      s_tvalid <= 1'b0;
      blank_all();
    end else begin
      if (s_tvalid && s_tready) begin
        res = apply_request(in_flight);
        expected_results.push_back(res);
        if (res.scrolled) n_scrolls++;
        case (in_flight.act)
          ttcw_pkg::ACT_RECV:  n_bytes++;
          ttcw_pkg::ACT_READ:  n_reads++;
          ttcw_pkg::ACT_CLEAR: n_clears++;
          default: ;
        endcase
      end
      if (!s_tvalid || s_tready) begin
        calm = (n_sent >= 250 && n_sent < 400);
        if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          rq = pending_reqs.pop_front();
          // Aim the read at rows just written, using the cursor as it stands now.
          if (rq.near) begin
            r = cur_row - int'($urandom_range(0, 2));
            rq.row = ROW_W'((r < 0) ? 0 : r);
            rq.col = COL_W'($urandom_range(0, COLUMNS - 1));
          end
          in_flight = rq;
          s_tdata  <= {2'b00, rq.col, rq.row, rq.code, rq.act};
          s_tvalid <= 1'b1;
          n_sent++;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin
    screen_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $error("result 0x%06h arrived with no request pending", m_tdata);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[7:0] !== want.char_val) begin
            $error("cell_char: expected %0d, got %0d", want.char_val, m_tdata[7:0]);
            n_errors++;
          end
          if (m_tdata[14:8] !== want.ccol) begin
            $error("cursor_col: expected %0d, got %0d", want.ccol, m_tdata[14:8]);
            n_errors++;
          end
          if (m_tdata[19:15] !== want.crow) begin
            $error("cursor_row: expected %0d, got %0d", want.crow, m_tdata[19:15]);
            n_errors++;
          end
          if (m_tdata[20] !== want.bell) begin
            $error("bell: expected %0b, got %0b", want.bell, m_tdata[20]);
            n_errors++;
          end
          if (m_tdata[21] !== want.scrolled) begin
            $error("scrolled: expected %0b, got %0b", want.scrolled, m_tdata[21]);
            n_errors++;
          end
        end
      end
      if (!hold_done && n_results >= 150) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (n_results >= 250 && n_results < 400) ||
                    ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("text_terminal_char_writer_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int pick;
    // Directed opening: blank reads, out-of-range read, unused action, bell,
    // byte extremes, tabbing to the last column and wrapping, escapes, CR, LF, clear.
    queue_req(ttcw_pkg::ACT_READ, rand_char(), 0, 0, 0);
    queue_req(ttcw_pkg::ACT_READ, rand_char(), 31, 127, 0);
    queue_req(ttcw_pkg::ACT_NONE, rand_char(), $urandom, $urandom, 0);
    queue_req(ttcw_pkg::ACT_RECV, ttcw_pkg::CODE_BELL, $urandom, $urandom, 0);
    queue_req(ttcw_pkg::ACT_RECV, 8'h00, $urandom, $urandom, 0);
    queue_req(ttcw_pkg::ACT_RECV, 8'hFF, $urandom, $urandom, 0);
    repeat (10) queue_req(ttcw_pkg::ACT_RECV, ttcw_pkg::CODE_TAB, $urandom, $urandom, 0);
    queue_req(ttcw_pkg::ACT_RECV, "Z", $urandom, $urandom, 0);
    queue_req(ttcw_pkg::ACT_RECV, ttcw_pkg::CODE_BS, $urandom, $urandom, 0);
    queue_req(ttcw_pkg::ACT_RECV, ttcw_pkg::CODE_ESC, $urandom, $urandom, 0);
    queue_req(ttcw_pkg::ACT_RECV, ttcw_pkg::CODE_ESC, $urandom, $urandom, 0);
    queue_req(ttcw_pkg::ACT_READ, rand_char(), 0, 0, 1);
    queue_req(ttcw_pkg::ACT_RECV, ttcw_pkg::CODE_BELL, $urandom, $urandom, 0);
    queue_req(ttcw_pkg::ACT_RECV, "Q", $urandom, $urandom, 0);
    queue_req(ttcw_pkg::ACT_RECV, ttcw_pkg::CODE_CR, $urandom, $urandom, 0);
    queue_req(ttcw_pkg::ACT_RECV, ttcw_pkg::CODE_LF, $urandom, $urandom, 0);
    queue_req(ttcw_pkg::ACT_READ, rand_char(), 0, 0, 1);
    queue_req(ttcw_pkg::ACT_CLEAR, rand_char(), $urandom, $urandom, 0);

    // Mostly text with line control; clears stay rare so the cursor reaches the bottom.
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        queue_req(ttcw_pkg::ACT_RECV, rand_char(), $urandom, $urandom, 0);
      else if (pick < 57)
        queue_req(ttcw_pkg::ACT_RECV, ttcw_pkg::CODE_LF, $urandom, $urandom, 0);
      else if (pick < 61)
        queue_req(ttcw_pkg::ACT_RECV, ttcw_pkg::CODE_CR, $urandom, $urandom, 0);
      else if (pick < 65)
        queue_req(ttcw_pkg::ACT_RECV, ttcw_pkg::CODE_TAB, $urandom, $urandom, 0);
      else if (pick < 68)
        queue_req(ttcw_pkg::ACT_RECV, ttcw_pkg::CODE_BS, $urandom, $urandom, 0);
      else if (pick < 70)
        queue_req(ttcw_pkg::ACT_RECV, ttcw_pkg::CODE_BELL, $urandom, $urandom, 0);
      else if (pick < 73)
        queue_req(ttcw_pkg::ACT_RECV, ttcw_pkg::CODE_ESC, $urandom, $urandom, 0);
      else if (pick < 90)
        queue_req(ttcw_pkg::ACT_READ, rand_char(), 0, 0, 1);
      else if (pick < 95)
        queue_req(ttcw_pkg::ACT_READ, rand_char(), $urandom, $urandom, 0);
      else if (pick < 98)
        queue_req(ttcw_pkg::ACT_NONE, rand_char(), $urandom, $urandom, 0);
      else
        queue_req(ttcw_pkg::action_t'($urandom_range(0, 3)), rand_char(),
                  $urandom, $urandom, 0);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Checked %0d results: %0d bytes, %0d reads, %0d clears.",
             n_results, n_bytes, n_reads, n_clears);
    $display("Line wraps: %0d, screen scrolls: %0d, receiver hold-off: %0d cycles.",
             n_wraps, n_scrolls, HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("text_terminal_char_writer_core: match");
    end else begin
      $display("text_terminal_char_writer_core: mismatch");
    end
    $finish;
  end

endmodule
